@@ design/dmac_pkg.sv @@
`timescale 1ns / 1ps
// dmac_pkg: types, codes and constants shared by the DMA controller files.
// Depends on nothing.
package dmac_pkg;

   localparam int CHANNELS = 7;
   // register RAM: one word per {register, channel slot}, three registers of eight slots
   localparam int RamDepth = 24;
   localparam int RamAw    = $clog2(RamDepth);

   localparam logic [2:0] NumChan = 3'(CHANNELS);
   localparam logic [2:0] ChanCommon = 3'd7;
   localparam logic [2:0] Idx2 = 3'(2 % CHANNELS);
   localparam logic [2:0] Idx6 = 3'(6 % CHANNELS);
   localparam logic Chan6Present = (CHANNELS > 6);

   // item function codes
   localparam logic [1:0] FuncRead  = 2'd0;
   localparam logic [1:0] FuncWrite = 2'd1;
   localparam logic [1:0] FuncSlot  = 2'd2;

   // bus access codes
   localparam logic [1:0] BusNone  = 2'd0;
   localparam logic [1:0] BusRead  = 2'd1;
   localparam logic [1:0] BusWrite = 2'd2;

   // register codes within a channel / the common block
   localparam logic [1:0] RegBase  = 2'd0;
   localparam logic [1:0] RegCount = 2'd1;
   localparam logic [1:0] RegCtrl  = 2'd2;
   localparam logic [1:0] RegEnable = 2'd0;
   localparam logic [1:0] RegIrq    = 2'd1;
   localparam logic [1:0] RegFixA   = 2'd2;

   // list walk phases
   localparam logic [1:0] PhHead = 2'd0;
   localparam logic [1:0] PhHdr  = 2'd1;
   localparam logic [1:0] PhRead = 2'd2;
   localparam logic [1:0] PhSend = 2'd3;

   localparam logic [31:0] IrqWrMask  = 32'h00ff803f;
   localparam logic [31:0] IrqFlags   = 32'h7f000000;
   localparam logic [31:0] IrqKeep    = 32'hff000000;
   localparam logic [31:0] CtrlWrMask = 32'h71770703;
   localparam logic [31:0] StartP2m   = 32'h01000200;
   localparam logic [31:0] StartM2p   = 32'h01000201;
   localparam logic [31:0] StartList  = 32'h01000401;
   localparam logic [31:0] StartClr   = 32'h11000002;
   localparam logic [31:0] PortAddr   = 32'h1f801810;
   localparam logic [31:0] FixWordA   = 32'h7ffac68b;
   localparam logic [31:0] FixWordB   = 32'h00fffff7;
   localparam logic [23:0] ListEnd    = 24'hffffff;
   localparam logic [31:0] Clear2     = 32'h01000000;
   localparam logic [31:0] Clear6     = 32'h11000000;

   typedef enum logic [4:0] {
      ActIdle = 5'b00001,
      ActP2m  = 5'b00010,
      ActM2p  = 5'b00100,
      ActList = 5'b01000,
      ActClr  = 5'b10000
   } act_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [6:0]  reg_offset;
      logic [31:0] write_data;
      logic [31:0] bus_read_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  bus_op;
      logic [31:0] bus_address;
      logic [31:0] bus_write_data;
      logic        irq_raise;
      logic        transfer_done;
      logic        busy_res;
   } rsp_type;

   typedef struct packed {
      logic [31:0] value;
      logic        rose;
   } irq_upd_type;

   function automatic logic [16:0] size_of(input logic [15:0] v);
      return (v == 16'd0) ? 17'h10000 : {1'b0, v};
   endfunction

   function automatic irq_upd_type irq_master(input logic [31:0] d);
      irq_upd_type u;
      logic on;
      on = d[15] | (d[23] & (|(d[22:16] & d[30:24])));
      u.rose  = on & ~d[31];
      u.value = {on, d[30:0]};
      return u;
   endfunction

   function automatic irq_upd_type irq_finish(input logic [31:0] d, input logic [2:0] ch);
      logic [31:0] t;
      t = d;
      if (d[5'd16 + {2'b00, ch}]) begin
         t[5'd24 + {2'b00, ch}] = 1'b1;
      end
      return irq_master(t);
   endfunction

endpackage

@@ design/dmac_ram.sv @@
`timescale 1ns / 1ps
// dmac_ram: generic single-write, single-read RAM with registered read.
// Depends on nothing.
module dmac_ram #(
   parameter int Width = 32,
   parameter int Depth = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/dma_controller_with_irq_and_list_walk.sv @@
`timescale 1ns / 1ps
// DMA controller top level: register window, transfer engine, response pipe.
// Depends on dmac_pkg and dmac_ram.
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_ready | req_item (req_type)
//  rsp_    | out       | rsp_valid/rsp_ready | rsp_item (rsp_type)
//
// One item per clock sustained while the output is not stalled. An item is
// fully decided at acceptance; its response is registered in stage 1 while
// the register RAM read completes, then sits in the output register.
// Reset clears control and transfer state and the per-word written flags of
// the register RAM; an unwritten channel register reads as zero.
// Channels 2 and 6 are mirrored in flops for the engine.
// A stalled output stalls stage 1, which in turn drops req_ready.
module dma_controller_with_irq_and_list_walk
   import dmac_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   // --- architectural state ---
   logic [31:0] en_ff, en_in, irq_ff, irq_in;
   logic [23:0] b2_ff, b2_in, b6_ff, b6_in;
   logic [31:0] k2_ff, k2_in, k6_ff, k6_in;
   logic [31:0] c2_ff, c2_in, c6_ff, c6_in;
   act_type     act_ff, act_in;
   logic [1:0]  ph_ff, ph_in;
   logic [31:0] wa_ff, wa_in;
   logic [16:0] wl_ff, wl_in, bl_ff, bl_in;
   logic [7:0]  lw_ff, lw_in;
   logic [23:0] lp_ff, lp_in;

   // --- pipe ---
   logic        s1_valid_ff, out_valid_ff;
   rsp_type     s1_rsp_ff, out_ff, s1_rsp_in;
   logic        s1_ram_ff, s1_ram_in;
   logic        s1_known_ff;
   logic [RamDepth-1:0] known_ff;

   logic        req_fire, advance;
   logic [2:0]  ch;
   logic [1:0]  rsel;
   logic        we_base, we_count, we_ctrl, start;
   logic        ram_we;
   logic [RamAw-1:0] ram_addr;
   logic [31:0] ram_wdata, ram_rdata;
   act_type     kind;
   irq_upd_type iu;

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || !out_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign ch        = req_item.reg_offset[6:4];
   assign rsel      = req_item.reg_offset[3:2];

   always_comb begin
      en_in = en_ff; irq_in = irq_ff;
      b2_in = b2_ff; k2_in = k2_ff; c2_in = c2_ff;
      b6_in = b6_ff; k6_in = k6_ff; c6_in = c6_ff;
      act_in = act_ff; ph_in = ph_ff; wa_in = wa_ff;
      wl_in = wl_ff; bl_in = bl_ff; lw_in = lw_ff; lp_in = lp_ff;
      s1_rsp_in = '0;
      s1_ram_in = 1'b0;
      we_base = 1'b0; we_count = 1'b0; we_ctrl = 1'b0;
      start = 1'b0;
      kind = ActIdle;
      iu = '0;
      if (req_fire) begin
         unique case (req_item.func)
            FuncRead: begin
               if (ch == ChanCommon) begin
                  unique case (rsel)
                     RegEnable: s1_rsp_in.read_data = en_ff;
                     RegIrq:    s1_rsp_in.read_data = irq_ff;
                     RegFixA:   s1_rsp_in.read_data = FixWordA;
                     default:   s1_rsp_in.read_data = FixWordB;
                  endcase
               end else if (ch < NumChan && rsel != 2'd3) begin
                  if (ch == Idx2) begin
                     unique case (rsel)
                        RegBase:  s1_rsp_in.read_data = {8'd0, b2_ff};
                        RegCount: s1_rsp_in.read_data = k2_ff;
                        default:  s1_rsp_in.read_data = c2_ff;
                     endcase
                  end else if (Chan6Present && ch == Idx6) begin
                     unique case (rsel)
                        RegBase:  s1_rsp_in.read_data = {8'd0, b6_ff};
                        RegCount: s1_rsp_in.read_data = k6_ff;
                        default:  s1_rsp_in.read_data = c6_ff;
                     endcase
                  end else begin
                     s1_ram_in = 1'b1;
                  end
               end
            end
            FuncWrite: begin
               start = 1'b1;
               if (ch == ChanCommon) begin
                  if (rsel == RegEnable) begin
                     en_in = req_item.write_data;
                  end else if (rsel == RegIrq) begin
                     iu = irq_master(((irq_ff & IrqKeep) | (req_item.write_data & IrqWrMask))
                                     & ~(req_item.write_data & IrqFlags));
                     irq_in = iu.value;
                     s1_rsp_in.irq_raise = iu.rose;
                  end
               end else if (ch < NumChan) begin
                  we_base  = (rsel == RegBase);
                  we_count = (rsel == RegCount);
                  we_ctrl  = (rsel == RegCtrl);
                  if (ch == Idx2) begin
                     if (we_base)  b2_in = req_item.write_data[23:0];
                     if (we_count) k2_in = req_item.write_data;
                     if (we_ctrl)  c2_in = req_item.write_data & CtrlWrMask;
                  end
                  if (Chan6Present && ch == Idx6) begin
                     if (we_base)  b6_in = req_item.write_data[23:0];
                     if (we_count) k6_in = req_item.write_data;
                     if (we_ctrl)  c6_in = req_item.write_data & CtrlWrMask;
                  end
               end
            end
            FuncSlot: begin
               unique case (act_ff)
                  ActP2m, ActM2p: begin
                     if (ph_ff == 2'd0) begin
                        s1_rsp_in.bus_op = BusRead;
                        s1_rsp_in.bus_address = (act_ff == ActP2m) ? PortAddr : wa_ff;
                        ph_in = 2'd1;
                     end else begin
                        s1_rsp_in.bus_op = BusWrite;
                        s1_rsp_in.bus_address = (act_ff == ActP2m) ? wa_ff : PortAddr;
                        s1_rsp_in.bus_write_data = req_item.bus_read_data;
                        wa_in = wa_ff + 32'd4;
                        ph_in = 2'd0;
                        wl_in = wl_ff - 17'd1;
                        if (wl_in == 17'd0) begin
                           bl_in = bl_ff - 17'd1;
                           if (bl_in == 17'd0) begin
                              c2_in = c2_ff & ~Clear2;
                              iu = irq_finish(irq_ff, 3'd2);
                              act_in = ActIdle;
                           end else begin
                              wl_in = size_of(k2_ff[15:0]);
                           end
                        end
                     end
                  end
                  ActList: begin
                     unique case (ph_ff)
                        PhHead, PhRead: begin
                           s1_rsp_in.bus_op = BusRead;
                           s1_rsp_in.bus_address = wa_ff;
                           wa_in = wa_ff + 32'd4;
                           ph_in = (ph_ff == PhHead) ? PhHdr : PhSend;
                        end
                        PhHdr: begin
                           lw_in = req_item.bus_read_data[31:24];
                           lp_in = req_item.bus_read_data[23:0];
                           if (lw_in != 8'd0) begin
                              s1_rsp_in.bus_op = BusRead;
                              s1_rsp_in.bus_address = wa_ff;
                              wa_in = wa_ff + 32'd4;
                              ph_in = PhSend;
                           end else if (lp_in == ListEnd) begin
                              wa_in = {8'd0, lp_in};
                              c2_in = c2_ff & ~Clear2;
                              iu = irq_finish(irq_ff, 3'd2);
                              act_in = ActIdle;
                           end else begin
                              s1_rsp_in.bus_op = BusRead;
                              s1_rsp_in.bus_address = {8'd0, lp_in};
                              wa_in = {8'd0, lp_in} + 32'd4;
                           end
                        end
                        default: begin
                           s1_rsp_in.bus_op = BusWrite;
                           s1_rsp_in.bus_address = PortAddr;
                           s1_rsp_in.bus_write_data = req_item.bus_read_data;
                           lw_in = lw_ff - 8'd1;
                           if (lw_in != 8'd0) begin
                              ph_in = PhRead;
                           end else begin
                              wa_in = {8'd0, lp_ff};
                              if (lp_ff == ListEnd) begin
                                 c2_in = c2_ff & ~Clear2;
                                 iu = irq_finish(irq_ff, 3'd2);
                                 act_in = ActIdle;
                              end else begin
                                 ph_in = PhHead;
                              end
                           end
                        end
                     endcase
                  end
                  ActClr: begin
                     s1_rsp_in.bus_op = BusWrite;
                     s1_rsp_in.bus_address = wa_ff;
                     if (wl_ff > 17'd1) begin
                        s1_rsp_in.bus_write_data = wa_ff - 32'd4;
                        wa_in = wa_ff - 32'd4;
                        wl_in = wl_ff - 17'd1;
                     end else begin
                        s1_rsp_in.bus_write_data = {8'd0, ListEnd};
                        c6_in = c6_ff & ~Clear6;
                        iu = irq_finish(irq_ff, 3'd6);
                        act_in = ActIdle;
                     end
                  end
                  default: ;
               endcase
               if (act_ff != ActIdle && act_in == ActIdle) begin
                  irq_in = iu.value;
                  s1_rsp_in.irq_raise = iu.rose;
                  s1_rsp_in.transfer_done = 1'b1;
                  ph_in = 2'd0;
                  start = 1'b1;
               end
            end
            default: ;
         endcase

         // start check: channel 6 has priority over channel 2
         if (start && act_in == ActIdle) begin
            if (Chan6Present && en_in[27] && c6_in == StartClr) begin
               act_in = ActClr;
               ph_in  = 2'd0;
               wa_in  = {8'd0, b6_in};
               wl_in  = size_of(k6_in[15:0]);
            end else if (en_in[11]) begin
               priority if (c2_in == StartP2m) kind = ActP2m;
               else if (c2_in == StartM2p)     kind = ActM2p;
               else if (c2_in == StartList)    kind = ActList;
               else                            kind = ActIdle;
               if (kind != ActIdle) begin
                  act_in = kind;
                  ph_in  = 2'd0;
                  wa_in  = {8'd0, b2_in};
                  wl_in  = size_of(k2_in[15:0]);
                  bl_in  = size_of(k2_in[31:16]);
                  if (kind == ActList && b2_in == ListEnd) begin
                     c2_in = c2_in & ~Clear2;
                     iu = irq_finish(irq_in, 3'd2);
                     irq_in = iu.value;
                     s1_rsp_in.irq_raise = s1_rsp_in.irq_raise | iu.rose;
                     s1_rsp_in.transfer_done = 1'b1;
                     act_in = ActIdle;
                     ph_in = 2'd0;
                  end
               end
            end
         end
         s1_rsp_in.busy_res = (act_in != ActIdle);
      end
   end

   // channel registers: one RAM, word address {register, channel}
   assign ram_addr = {rsel, ch};
   assign ram_we   = we_base | we_count | we_ctrl;

   always_comb begin
      unique case (rsel)
         RegBase: ram_wdata = {8'd0, req_item.write_data[23:0]};
         RegCtrl: ram_wdata = req_item.write_data & CtrlWrMask;
         default: ram_wdata = req_item.write_data;
      endcase
   end

   dmac_ram #(.Width(32), .Depth(RamDepth)) u_regs (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_addr),
      .wr_data(ram_wdata), .rd_en(req_fire),
      .rd_addr(ram_addr), .rd_data(ram_rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= '0; irq_ff <= '0;
         b2_ff <= '0; k2_ff <= '0; c2_ff <= '0;
         b6_ff <= '0; k6_ff <= '0; c6_ff <= '0;
         act_ff <= ActIdle; ph_ff <= '0; wa_ff <= '0;
         wl_ff <= '0; bl_ff <= '0; lw_ff <= '0; lp_ff <= '0;
         known_ff <= '0;
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         en_ff <= en_in; irq_ff <= irq_in;
         b2_ff <= b2_in; k2_ff <= k2_in; c2_ff <= c2_in;
         b6_ff <= b6_in; k6_ff <= k6_in; c6_ff <= c6_in;
         act_ff <= act_in; ph_ff <= ph_in; wa_ff <= wa_in;
         wl_ff <= wl_in; bl_ff <= bl_in; lw_ff <= lw_in; lp_ff <= lp_in;
         if (ram_we) begin
            known_ff[ram_addr] <= 1'b1;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_rsp_ff <= s1_rsp_in;
         s1_ram_ff <= s1_ram_in;
         s1_known_ff <= known_ff[ram_addr];
      end
      if (advance) begin
         out_ff <= s1_rsp_ff;
         // never-written word: keep the zero from stage 1
         if (s1_ram_ff && s1_known_ff) begin
            out_ff.read_data <= ram_rdata;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("input blocked with stage 1 empty");

   a_busy_tracks_state: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (s1_rsp_ff.busy_res == (act_ff != ActIdle)))
      else $error("busy flag disagrees with transfer state");

   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> ($stable(s1_rsp_ff) && s1_valid_ff))
      else $error("stage 1 lost its item while stalled");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && s1_rsp_in.transfer_done && req_item.func == FuncSlot
       && !start) |=> act_ff == ActIdle)
      else $error("transfer finished but engine not idle");

endmodule
